### sv/heading_pid_controller_assert.svh
// assertion macros for the heading pid controller
`ifndef HEADING_PID_CONTROLLER_ASSERT_SVH
`define HEADING_PID_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define HPID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define HPID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/hpid_pkg.sv
// shared widths, step counts and unit control type of the heading pid controller
`default_nettype none

package hpid_pkg;

	// field and state widths
	localparam int GAIN_W  = 24;
	localparam int ANG_W   = 15;
	localparam int T_W     = 16;
	localparam int INTEG_W = 48;
	localparam int PREV_W  = 16;

	// serial multiplier: gain times a 48-bit operand
	localparam int MUL_B_W   = 48;
	localparam int MUL_P_W   = GAIN_W + MUL_B_W;
	localparam int MUL_STEPS = MUL_B_W;

	// angle scale of 64 is a right shift
	localparam int ANGLE_SHIFT = 6;

	// serial divider: numerator is the product after the angle shift
	localparam int DIV_N_W   = MUL_P_W - ANGLE_SHIFT;
	localparam int DIV_D_W   = T_W;
	localparam int DIV_STEPS = DIV_N_W;

	// term magnitudes and signed sum
	localparam int P_W   = 33;
	localparam int I_W   = 56;
	localparam int D_W   = 45;
	localparam int SUM_W = 58;

	// sequencer step counter
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	// milliseconds per second
	localparam logic [DIV_D_W-1:0] MS_PER_S = 16'd1000;

	// load and step strobes from the sequencer to a serial unit
	typedef struct packed {
		logic load;
		logic step;
	} unit_ctl_t;

endpackage

`default_nettype wire

### sv/hpid_serial_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle while step is asserted
`default_nettype none

module hpid_serial_mul (
	input  wire                              clk,
	input  hpid_pkg::unit_ctl_t              ctl,
	input  wire  [hpid_pkg::GAIN_W-1:0]      multiplicand,
	input  wire  [hpid_pkg::MUL_B_W-1:0]     multiplier,
	output logic [hpid_pkg::MUL_P_W-1:0]     product
);

	logic [hpid_pkg::GAIN_W-1:0]  mcand_q;
	logic [hpid_pkg::GAIN_W-1:0]  hi_q;
	logic [hpid_pkg::MUL_B_W-1:0] lo_q;
	logic [hpid_pkg::GAIN_W:0]    partial;

	// add the multiplicand when the current multiplier bit is set
	assign partial = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	// shift the running product right one bit per step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q <= multiplicand;
			hi_q    <= '0;
			lo_q    <= multiplier;
		end else if (ctl.step) begin
			hi_q <= partial[hpid_pkg::GAIN_W:1];
			lo_q <= {partial[0], lo_q[hpid_pkg::MUL_B_W-1:1]};
		end
	end

	assign product = {hi_q, lo_q};

endmodule

`default_nettype wire

### sv/hpid_serial_div.sv
// bit-serial restoring divider, one quotient bit per cycle while step is asserted
`default_nettype none

module hpid_serial_div (
	input  wire                              clk,
	input  hpid_pkg::unit_ctl_t              ctl,
	input  wire  [hpid_pkg::DIV_N_W-1:0]     numerator,
	input  wire  [hpid_pkg::DIV_D_W-1:0]     divisor,
	output logic [hpid_pkg::DIV_N_W-1:0]     quotient
);

	logic [hpid_pkg::DIV_N_W-1:0] num_q;
	logic [hpid_pkg::DIV_D_W:0]   rem_q;
	logic [hpid_pkg::DIV_D_W-1:0] dvs_q;
	logic [hpid_pkg::DIV_D_W:0]   shifted;
	logic                         fits;

	// bring down the next numerator bit and trial subtract
	assign shifted = {rem_q[hpid_pkg::DIV_D_W-1:0], num_q[hpid_pkg::DIV_N_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	// quotient bits shift in where the numerator bits leave
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= numerator;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (ctl.step) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			num_q <= {num_q[hpid_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign quotient = num_q;

endmodule

`default_nettype wire

### sv/heading_pid_controller.sv
// heading pid controller top level: sequencer, state, serial multipliers and dividers
//
// One heading sample in, one control word out. A new input transfer is taken
// only once the previous item has left the sequencer, and the last step waits
// while an earlier result is still held in the output register. A finished
// result waits in the output register while the next item is already being
// worked on. The bit-serial units set the pace: three shift-add multipliers run
// 48 steps side by side (gain times error, integral and error change), then two
// restoring dividers run 66 steps side by side (integral term by 1000,
// derivative term by the elapsed time), followed by the wrap, integral update,
// unit loads and final sum and saturation. Gains are to be written through the
// cfg port only while no item is in flight; the block itself does not enforce
// this. A write to an unknown index is ignored. There is no clearing pass after
// reset.
`default_nettype none

module heading_pid_controller (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // heading[14:0], target[29:15], elapsed_ms[45:30], restart[46]
	// output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // control[31:0], clockwise[32], heading_error[47:33]
	// configuration writes
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [23:0] cfg_data
);

	localparam logic [1:0] REG_GAIN_P = 2'd0;
	localparam logic [1:0] REG_GAIN_I = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;

	localparam logic [hpid_pkg::GAIN_W-1:0] GAIN_P_RST = 24'd3932;
	localparam logic [hpid_pkg::GAIN_W-1:0] GAIN_I_RST = 24'd1311;
	localparam logic [hpid_pkg::GAIN_W-1:0] GAIN_D_RST = 24'd328;

	localparam logic signed [15:0] HALF_TURN = 16'sd11520;
	localparam logic signed [15:0] FULL_TURN = 16'sd23040;

	localparam logic [hpid_pkg::INTEG_W-1:0] INTEG_MAX = {1'b0, {(hpid_pkg::INTEG_W-1){1'b1}}};
	localparam logic [hpid_pkg::INTEG_W-1:0] INTEG_MIN = {1'b1, {(hpid_pkg::INTEG_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_ACC,
		ST_START,
		ST_MUL,
		ST_DIVLD,
		ST_DIV,
		ST_SUM1,
		ST_SUM2,
		ST_SAT
	} state_t;

	state_t state_q;
	logic [hpid_pkg::CNT_W-1:0]   cnt_q;
	logic [hpid_pkg::GAIN_W-1:0]  gain_p_q;
	logic [hpid_pkg::GAIN_W-1:0]  gain_i_q;
	logic [hpid_pkg::GAIN_W-1:0]  gain_d_q;
	logic [hpid_pkg::INTEG_W-1:0] integ_q;
	logic [hpid_pkg::PREV_W-1:0]  prev_q;
	logic                         m_tvalid_q;
	logic [47:0]                  m_tdata_q;

	// per-item working registers
	logic [hpid_pkg::ANG_W-1:0]   err_q;
	logic [hpid_pkg::T_W-1:0]     t_q;
	logic [16:0]                  de_q;
	logic [hpid_pkg::INTEG_W-1:0] base_q;
	logic [30:0]                  et_q;
	logic [25:0]                  de1000_q;
	logic [hpid_pkg::SUM_W-1:0]   sp_q;
	logic [hpid_pkg::SUM_W-1:0]   pi_q;
	logic [hpid_pkg::SUM_W-1:0]   sum_q;

	logic                         in_xfer;
	logic signed [15:0]           head_x;
	logic signed [15:0]           tgt_x;
	logic signed [15:0]           diff;
	logic signed [15:0]           wrapped;
	logic [hpid_pkg::PREV_W-1:0]  prev_base;
	logic [16:0]                  de_new;
	logic [15:0]                  de_mag;
	logic [hpid_pkg::ANG_W-1:0]   err_mag;
	logic signed [31:0]           et_full;
	logic [hpid_pkg::INTEG_W:0]   acc_sum;
	logic [hpid_pkg::INTEG_W-1:0] acc_sat;
	logic [hpid_pkg::INTEG_W-1:0] integ_mag;

	hpid_pkg::unit_ctl_t          mul_ctl;
	hpid_pkg::unit_ctl_t          div_ctl;
	logic [hpid_pkg::MUL_P_W-1:0] prod_p;
	logic [hpid_pkg::MUL_P_W-1:0] prod_i;
	logic [hpid_pkg::MUL_P_W-1:0] prod_d;
	logic [hpid_pkg::DIV_N_W-1:0] quo_i;
	logic [hpid_pkg::DIV_N_W-1:0] quo_d;

	logic [hpid_pkg::P_W-1:0]     p_val;
	logic [hpid_pkg::SUM_W-1:0]   p_ext;
	logic [hpid_pkg::SUM_W-1:0]   i_ext;
	logic [hpid_pkg::SUM_W-1:0]   d_ext;
	logic                         sum_fits;
	logic [31:0]                  control_sat;
	logic                         clockwise;

	// output fields as seen by the checks
	logic signed [hpid_pkg::ANG_W-1:0] res_err;
	logic signed [31:0]                res_control;
	logic                              res_err_ok;
	logic                              res_cw_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// heading error wrapped once into half a turn either way
	assign head_x = {s_tdata[14], s_tdata[14:0]};
	assign tgt_x  = {s_tdata[29], s_tdata[29:15]};
	assign diff   = head_x - tgt_x;
	always_comb begin
		if (diff > HALF_TURN) begin
			wrapped = diff - FULL_TURN;
		end else if (diff < -HALF_TURN) begin
			wrapped = diff + FULL_TURN;
		end else begin
			wrapped = diff;
		end
	end

	// error change against the previous error, cleared on restart
	assign prev_base = s_tdata[46] ? '0 : prev_q;
	assign de_new    = {wrapped[15], wrapped} - {prev_base[15], prev_base};

	// error times elapsed time and scaled error change
	assign et_full = $signed(err_q) * $signed({1'b0, t_q});
	assign de_mag  = de_q[16] ? 16'(-de_q) : de_q[15:0];

	// integral update with 48-bit saturation
	assign acc_sum = {base_q[hpid_pkg::INTEG_W-1], base_q}
		+ {{(hpid_pkg::INTEG_W - 30){et_q[30]}}, et_q};
	assign acc_sat = (acc_sum[hpid_pkg::INTEG_W] != acc_sum[hpid_pkg::INTEG_W-1])
		? (acc_sum[hpid_pkg::INTEG_W] ? INTEG_MIN : INTEG_MAX)
		: acc_sum[hpid_pkg::INTEG_W-1:0];

	// operand magnitudes for the multipliers
	assign err_mag   = err_q[hpid_pkg::ANG_W-1] ? -err_q : err_q;
	assign integ_mag = integ_q[hpid_pkg::INTEG_W-1] ? -integ_q : integ_q;

	// serial unit strobes
	assign mul_ctl.load = (state_q == ST_START);
	assign mul_ctl.step = (state_q == ST_MUL);
	assign div_ctl.load = (state_q == ST_DIVLD);
	assign div_ctl.step = (state_q == ST_DIV);

	hpid_serial_mul u_mul_p (
		.clk          (clk),
		.ctl          (mul_ctl),
		.multiplicand (gain_p_q),
		.multiplier   ({{(hpid_pkg::MUL_B_W - hpid_pkg::ANG_W){1'b0}}, err_mag}),
		.product      (prod_p)
	);

	hpid_serial_mul u_mul_i (
		.clk          (clk),
		.ctl          (mul_ctl),
		.multiplicand (gain_i_q),
		.multiplier   (integ_mag),
		.product      (prod_i)
	);

	hpid_serial_mul u_mul_d (
		.clk          (clk),
		.ctl          (mul_ctl),
		.multiplicand (gain_d_q),
		.multiplier   ({{(hpid_pkg::MUL_B_W - 26){1'b0}}, de1000_q}),
		.product      (prod_d)
	);

	hpid_serial_div u_div_i (
		.clk       (clk),
		.ctl       (div_ctl),
		.numerator (prod_i[hpid_pkg::MUL_P_W-1:hpid_pkg::ANGLE_SHIFT]),
		.divisor   (hpid_pkg::MS_PER_S),
		.quotient  (quo_i)
	);

	hpid_serial_div u_div_d (
		.clk       (clk),
		.ctl       (div_ctl),
		.numerator (prod_d[hpid_pkg::MUL_P_W-1:hpid_pkg::ANGLE_SHIFT]),
		.divisor   (t_q),
		.quotient  (quo_d)
	);

	// term magnitudes widened to the sum width
	assign p_val = prod_p[hpid_pkg::ANGLE_SHIFT +: hpid_pkg::P_W];
	assign p_ext = {{(hpid_pkg::SUM_W - hpid_pkg::P_W){1'b0}}, p_val};
	assign i_ext = {{(hpid_pkg::SUM_W - hpid_pkg::I_W){1'b0}}, quo_i[hpid_pkg::I_W-1:0]};
	assign d_ext = (t_q == '0) ? '0
		: {{(hpid_pkg::SUM_W - hpid_pkg::D_W){1'b0}}, quo_d[hpid_pkg::D_W-1:0]};

	// final saturation to 32 bits and sign flag
	assign sum_fits = (&sum_q[hpid_pkg::SUM_W-1:31]) || !(|sum_q[hpid_pkg::SUM_W-1:31]);
	assign control_sat = sum_fits ? sum_q[31:0]
		: (sum_q[hpid_pkg::SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
	assign clockwise = !sum_q[hpid_pkg::SUM_W-1] && (sum_q != '0);

	// sequencer, gains, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			gain_p_q   <= GAIN_P_RST;
			gain_i_q   <= GAIN_I_RST;
			gain_d_q   <= GAIN_D_RST;
			integ_q    <= '0;
			prev_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_P: gain_p_q <= cfg_data;
					REG_GAIN_I: gain_i_q <= cfg_data;
					REG_GAIN_D: gain_d_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// output register empties on a transfer unless a new result loads it
			if (m_tvalid_q && m_tready && (state_q != ST_SAT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					integ_q <= acc_sat;
					prev_q  <= {err_q[hpid_pkg::ANG_W-1], err_q};
					state_q <= ST_START;
				end
				ST_START: begin
					cnt_q   <= hpid_pkg::MUL_LAST;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIVLD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIVLD: begin
					cnt_q   <= hpid_pkg::DIV_LAST;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUM1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SUM1: begin
					state_q <= ST_SUM2;
				end
				ST_SUM2: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {err_q, clockwise, control_sat};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_q  <= wrapped[hpid_pkg::ANG_W-1:0];
			t_q    <= s_tdata[45:30];
			de_q   <= de_new;
			base_q <= s_tdata[46] ? '0 : integ_q;
		end
		if (state_q == ST_PREP) begin
			et_q     <= et_full[30:0];
			de1000_q <= 26'(de_mag) * 26'(hpid_pkg::MS_PER_S);
		end
		if (state_q == ST_DIVLD) begin
			sp_q <= err_q[hpid_pkg::ANG_W-1] ? -p_ext : p_ext;
		end
		if (state_q == ST_SUM1) begin
			pi_q <= integ_q[hpid_pkg::INTEG_W-1] ? (sp_q - i_ext) : (sp_q + i_ext);
		end
		if (state_q == ST_SUM2) begin
			sum_q <= de_q[16] ? (pi_q - d_ext) : (pi_q + d_ext);
		end
	end

	// output fields for the checks
	assign res_err     = m_tdata_q[47:33];
	assign res_control = m_tdata_q[31:0];
	assign res_err_ok  = (res_err >= -HALF_TURN) && (res_err <= HALF_TURN);
	assign res_cw_ok   = m_tdata_q[32] == (res_control > 32'sd0);

	// checks on sequencing and result consistency
`include "heading_pid_controller_assert.svh"

	`HPID_ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_tready, "input taken while busy")
	`HPID_ASSERT_NOW(a_error_range, m_tvalid, res_err_ok, "heading error outside half turn")
	`HPID_ASSERT_NOW(a_clockwise_sign, m_tvalid, res_cw_ok, "clockwise flag disagrees with control")

endmodule

`default_nettype wire
